// ----- src/rss_pkg.sv -----
package rss_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_SUM  = 8'b0000_0100,
    ST_SQR  = 8'b0000_1000,
    ST_SQRT = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_ANG  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_SENS  = 2'd0;
  localparam logic [1:0] REG_THR   = 2'd1;
  localparam logic [1:0] REG_HYST  = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  // Input operation codes.
  localparam logic OP_MOVE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Number of entries in the arctangent table.
  localparam int AtanEntries = 24;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/rss_cordic.sv -----
module rss_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [16:0] x_in,
  input  logic signed [16:0] y_in,
  output logic               done,
  output logic [15:0]        angle
);

  localparam int NStep = (CORDIC_STEPS < rss_pkg::AtanEntries) ? CORDIC_STEPS
                                                                : rss_pkg::AtanEntries;
  localparam logic [4:0] LastIt = 5'(NStep - 1);

  logic signed [32:0] xc_r, xc_nxt, yc_r, yc_nxt;
  logic [31:0]        z_r, z_nxt;
  logic [4:0]         it_r, it_nxt;
  logic               busy_r, busy_nxt;
  logic               zero_r, zero_nxt;
  logic               done_r, done_nxt;
  logic [15:0]        angle_r, angle_nxt;
  logic signed [32:0] xs, ys, xsh, ysh;
  logic [31:0]        zr;

  // One rotation per cycle; the shift follows the iteration count.
  always_comb begin
    xc_nxt    = xc_r;
    yc_nxt    = yc_r;
    z_nxt     = z_r;
    it_nxt    = it_r;
    busy_nxt  = busy_r;
    zero_nxt  = zero_r;
    done_nxt  = 1'b0;
    angle_nxt = angle_r;
    xs        = 33'(x_in) <<< 14;
    ys        = 33'(y_in) <<< 14;
    xsh       = xc_r >>> it_r;
    ysh       = yc_r >>> it_r;
    zr        = z_r + 32'h0000_8000;
    if (start) begin
      // Fold the left half plane onto the right one.
      if (x_in < 0) begin
        xc_nxt = -xs;
        yc_nxt = -ys;
        z_nxt  = 32'h8000_0000;
      end else begin
        xc_nxt = xs;
        yc_nxt = ys;
        z_nxt  = 32'd0;
      end
      zero_nxt = (x_in == 17'sd0) && (y_in == 17'sd0);
      it_nxt   = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!yc_r[32]) begin
        xc_nxt = xc_r + ysh;
        yc_nxt = yc_r - xsh;
        z_nxt  = z_r + rss_pkg::atan_turn(it_r);
      end else begin
        xc_nxt = xc_r - ysh;
        yc_nxt = yc_r + xsh;
        z_nxt  = z_r - rss_pkg::atan_turn(it_r);
      end
      it_nxt = it_r + 5'd1;
      if (it_r == LastIt) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        zr       = z_nxt + 32'h0000_8000;
        angle_nxt = zero_r ? 16'd0 : zr[31:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    xc_r    <= xc_nxt;
    yc_r    <= yc_nxt;
    z_r     <= z_nxt;
    it_r    <= it_nxt;
    zero_r  <= zero_nxt;
    angle_r <= angle_nxt;
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

// ----- src/radial_sector_selector.sv -----
// Channel | Direction | Handshake                        | Payload
// in_     | input     | in_tvalid / in_tready            | tuser operation, tdata deltas
// out_    | output    | out_tvalid / out_tready          | tdata angle, length, selection
// cfg_    | input     | cfg_psel / cfg_penable / pready  | four registers at 4*index
//
// A move item takes a serial gain multiply, a sum step, serial squaring, a serial square
// root, a division when the cursor leaves the unit circle, then CORDIC_STEPS (at most
// 24) rotations and the handoff. A clear item goes straight to the handoff.
// Reset is synchronous and active low; it restores the register defaults and clears
// the cursor and selection. A result that is not taken holds the block before its
// output register; input is taken only when the sequencer is idle.
module radial_sector_selector #(
  parameter int MAX_SECTORS  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // delta_x [15:0], delta_y [31:16]
  input  logic        in_tuser,    // operation [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // pointer_angle [15:0], pointer_length [31:16],
                                   // selection_valid [32], selected_sector [36:33]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CapInt = (MAX_SECTORS < 16) ? MAX_SECTORS : 16;
  localparam logic [4:0] Cap = 5'(CapInt);

  rss_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0] sens_r, thr_r, hyst_r;
  logic [4:0]  count_r;
  logic        cfg_wr;

  // Persistent state.
  logic signed [16:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic               held_r, held_nxt;
  logic [3:0]         sect_r, sect_nxt;

  // Datapath registers.
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [32:0] dx_mc_r, dx_mc_nxt, dy_mc_r, dy_mc_nxt;
  logic signed [32:0] px_r, px_nxt, py_r, py_nxt;
  logic [15:0]        sens_sh_r, sens_sh_nxt;
  logic signed [25:0] xv_r, xv_nxt, yv_r, yv_nxt;
  logic [24:0]        ax_sh_r, ax_sh_nxt, ay_sh_r, ay_sh_nxt;
  logic [49:0]        ax_mc_r, ax_mc_nxt, ay_mc_r, ay_mc_nxt;
  logic [49:0]        s_r, s_nxt, sq_s_r, sq_s_nxt;
  logic               big_r, big_nxt;
  logic [25:0]        rem_r, rem_nxt;
  logic [24:0]        root_r, root_nxt, m_r, m_nxt;
  logic [25:0]        rx_r, rx_nxt, ry_r, ry_nxt;
  logic [15:0]        qx_r, qx_nxt, qy_r, qy_nxt;
  logic [15:0]        len_r, len_nxt;
  logic               clr_r, clr_nxt;
  logic               start_r, start_nxt;

  // Output register.
  logic               ov_r, ov_nxt;
  logic [39:0]        od_r, od_nxt;

  // Combinational helpers.
  logic signed [32:0] sx, sy;
  logic [24:0]        ax, ay;
  logic [27:0]        rem_in, trial;
  logic [26:0]        tx, ty;
  logic               bx, by;
  logic               ang_done;
  logic [15:0]        ang;
  logic [4:0]         cnt_eff;
  logic signed [17:0] dead;
  logic [15:0]        u;
  logic [20:0]        prod;
  logic [21:0]        prod_r;
  logic [4:0]         vsec;
  logic               sel;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  // Register read.
  always_comb begin
    unique case (cfg_paddr[3:2])
      rss_pkg::REG_SENS:  cfg_prdata = {16'd0, sens_r};
      rss_pkg::REG_THR:   cfg_prdata = {16'd0, thr_r};
      rss_pkg::REG_HYST:  cfg_prdata = {16'd0, hyst_r};
      rss_pkg::REG_COUNT: cfg_prdata = {27'd0, count_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // Register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r  <= 16'd256;
      thr_r   <= 16'd16384;
      hyst_r  <= 16'd3277;
      count_r <= 5'd0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        rss_pkg::REG_SENS:  sens_r  <= cfg_pwdata[15:0];
        rss_pkg::REG_THR:   thr_r   <= cfg_pwdata[15:0];
        rss_pkg::REG_HYST:  hyst_r  <= cfg_pwdata[15:0];
        rss_pkg::REG_COUNT: count_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  rss_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .x_in  (cur_x_r),
    .y_in  (cur_y_r),
    .done  (ang_done),
    .angle (ang)
  );

  assign in_tready = (state_r == rss_pkg::ST_IDLE);

  // Sector selection from the finished angle and length.
  always_comb begin
    cnt_eff = (count_r > Cap) ? Cap : count_r;
    dead    = held_r ? (18'(thr_r) - 18'(hyst_r)) : 18'(thr_r);
    u       = 16'd16384 - ang;
    prod    = 21'(u) * 21'(cnt_eff);
    prod_r  = 22'(prod) + 22'd32768;
    vsec    = prod_r[20:16];
    sel     = ($signed({2'b00, len_r}) >= dead) && (cnt_eff != 5'd0);
    if (vsec == cnt_eff) begin
      vsec = 5'd0;
    end
  end

  // Sequencer and serial datapath.
  always_comb begin
    state_nxt   = state_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    held_nxt    = held_r;
    sect_nxt    = sect_r;
    cnt_nxt     = cnt_r + 5'd1;
    dx_mc_nxt   = dx_mc_r <<< 1;
    dy_mc_nxt   = dy_mc_r <<< 1;
    px_nxt      = px_r;
    py_nxt      = py_r;
    sens_sh_nxt = sens_sh_r >> 1;
    xv_nxt      = xv_r;
    yv_nxt      = yv_r;
    ax_sh_nxt   = ax_sh_r >> 1;
    ay_sh_nxt   = ay_sh_r >> 1;
    ax_mc_nxt   = ax_mc_r << 1;
    ay_mc_nxt   = ay_mc_r << 1;
    s_nxt       = s_r;
    sq_s_nxt    = sq_s_r << 2;
    big_nxt     = big_r;
    rem_nxt     = rem_r;
    root_nxt    = root_r;
    m_nxt       = m_r;
    rx_nxt      = rx_r;
    ry_nxt      = ry_r;
    qx_nxt      = qx_r;
    qy_nxt      = qy_r;
    len_nxt     = len_r;
    clr_nxt     = clr_r;
    start_nxt   = 1'b0;
    ov_nxt      = ov_r;
    od_nxt      = od_r;

    sx     = (px_r + 33'sd128) >>> 8;
    sy     = (py_r + 33'sd128) >>> 8;
    ax     = '0;
    ay     = '0;
    rem_in = {rem_r, sq_s_r[49:48]};
    trial  = {1'b0, root_r, 2'b01};
    tx     = {1'b0, rx_r} - {2'b00, m_r};
    ty     = {1'b0, ry_r} - {2'b00, m_r};
    bx     = !tx[26];
    by     = !ty[26];

    // A taken result frees the output register.
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      rss_pkg::ST_IDLE: begin
        cnt_nxt = 5'd0;
        if (in_tvalid) begin
          if (in_tuser == rss_pkg::OP_CLEAR) begin
            cur_x_nxt = '0;
            cur_y_nxt = '0;
            held_nxt  = 1'b0;
            sect_nxt  = 4'd0;
            clr_nxt   = 1'b1;
            state_nxt = rss_pkg::ST_OUT;
          end else begin
            dx_mc_nxt   = 33'($signed(in_tdata[15:0]));
            dy_mc_nxt   = 33'($signed(in_tdata[31:16]));
            sens_sh_nxt = sens_r;
            px_nxt      = '0;
            py_nxt      = '0;
            clr_nxt     = 1'b0;
            state_nxt   = rss_pkg::ST_MUL;
          end
        end
      end

      // Gain multiply, one sensitivity bit per cycle.
      rss_pkg::ST_MUL: begin
        if (sens_sh_r[0]) begin
          px_nxt = px_r + dx_mc_r;
          py_nxt = py_r + dy_mc_r;
        end
        if (cnt_r == 5'd15) begin
          state_nxt = rss_pkg::ST_SUM;
        end
      end

      // Round the scaled deltas and move the cursor.
      rss_pkg::ST_SUM: begin
        xv_nxt    = 26'(cur_x_r) + sx[25:0];
        yv_nxt    = 26'(cur_y_r) - sy[25:0];
        ax        = xv_nxt[25] ? 25'(-xv_nxt) : xv_nxt[24:0];
        ay        = yv_nxt[25] ? 25'(-yv_nxt) : yv_nxt[24:0];
        ax_sh_nxt = ax;
        ay_sh_nxt = ay;
        ax_mc_nxt = 50'(ax);
        ay_mc_nxt = 50'(ay);
        s_nxt     = '0;
        cnt_nxt   = 5'd0;
        state_nxt = rss_pkg::ST_SQR;
      end

      // Sum of squares, one multiplier bit per cycle for both axes.
      rss_pkg::ST_SQR: begin
        s_nxt = s_r + (ax_sh_r[0] ? ax_mc_r : 50'd0) + (ay_sh_r[0] ? ay_mc_r : 50'd0);
        if (cnt_r == 5'd24) begin
          sq_s_nxt  = s_nxt;
          big_nxt   = s_nxt > 50'd1073741824;
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = 5'd0;
          state_nxt = rss_pkg::ST_SQRT;
        end
      end

      // Restoring square root, two radicand bits per cycle.
      rss_pkg::ST_SQRT: begin
        if (rem_in >= trial) begin
          rem_nxt  = 26'(rem_in - trial);
          root_nxt = {root_r[23:0], 1'b1};
        end else begin
          rem_nxt  = rem_in[25:0];
          root_nxt = {root_r[23:0], 1'b0};
        end
        if (cnt_r == 5'd24) begin
          cnt_nxt = 5'd0;
          if (big_r) begin
            m_nxt     = root_nxt + 25'(rem_nxt != 26'd0);
            rx_nxt    = xv_r[25] ? 26'(-xv_r) : 26'(xv_r);
            ry_nxt    = yv_r[25] ? 26'(-yv_r) : 26'(yv_r);
            qx_nxt    = '0;
            qy_nxt    = '0;
            len_nxt   = 16'd32768;
            state_nxt = rss_pkg::ST_DIV;
          end else begin
            cur_x_nxt = xv_r[16:0];
            cur_y_nxt = yv_r[16:0];
            len_nxt   = root_nxt[15:0];
            start_nxt = 1'b1;
            state_nxt = rss_pkg::ST_ANG;
          end
        end
      end

      // Scale back onto the unit circle, one quotient bit per cycle.
      rss_pkg::ST_DIV: begin
        rx_nxt = (bx ? tx[25:0] : rx_r) << 1;
        ry_nxt = (by ? ty[25:0] : ry_r) << 1;
        qx_nxt = {qx_r[14:0], bx};
        qy_nxt = {qy_r[14:0], by};
        if (cnt_r == 5'd15) begin
          cur_x_nxt = xv_r[25] ? -$signed({1'b0, qx_nxt}) : $signed({1'b0, qx_nxt});
          cur_y_nxt = yv_r[25] ? -$signed({1'b0, qy_nxt}) : $signed({1'b0, qy_nxt});
          start_nxt = 1'b1;
          state_nxt = rss_pkg::ST_ANG;
        end
      end

      // Wait for the angle.
      rss_pkg::ST_ANG: begin
        if (ang_done) begin
          state_nxt = rss_pkg::ST_OUT;
        end
      end

      // Select the sector and hand the transfer to the output register.
      rss_pkg::ST_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          if (clr_r) begin
            od_nxt = '0;
          end else begin
            held_nxt = sel;
            sect_nxt = sel ? vsec[3:0] : 4'd0;
            od_nxt   = {3'd0, sect_nxt, sel, len_r, ang};
          end
          state_nxt = rss_pkg::ST_IDLE;
        end
      end

      default: state_nxt = rss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rss_pkg::ST_IDLE;
      cur_x_r <= '0;
      cur_y_r <= '0;
      held_r  <= 1'b0;
      sect_r  <= 4'd0;
      start_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      held_r  <= held_nxt;
      sect_r  <= sect_nxt;
      start_r <= start_nxt;
      ov_r    <= ov_nxt;
    end
    cnt_r     <= cnt_nxt;
    dx_mc_r   <= dx_mc_nxt;
    dy_mc_r   <= dy_mc_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    sens_sh_r <= sens_sh_nxt;
    xv_r      <= xv_nxt;
    yv_r      <= yv_nxt;
    ax_sh_r   <= ax_sh_nxt;
    ay_sh_r   <= ay_sh_nxt;
    ax_mc_r   <= ax_mc_nxt;
    ay_mc_r   <= ay_mc_nxt;
    s_r       <= s_nxt;
    sq_s_r    <= sq_s_nxt;
    big_r     <= big_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    m_r       <= m_nxt;
    rx_r      <= rx_nxt;
    ry_r      <= ry_nxt;
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    len_r     <= len_nxt;
    clr_r     <= clr_nxt;
    od_r      <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule

// ----- bench/tb_radial_sector_selector.sv -----
module tb_radial_sector_selector;

  localparam int MaxSectors  = 16;
  localparam int CordicSteps = 16;

  // Arctangent of 2^-i, 2^32 units per turn, for the angle predictor.
  localparam int unsigned ATAN_TBL [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] length;
    logic        sel_valid;
    logic [3:0]  sector;
  } pointer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // delta_x [15:0], delta_y [31:16]
  logic        in_tuser = 1'b0;  // operation [0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // angle [15:0], length [31:16], valid [32], sector [36:33]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  radial_sector_selector #(
    .MAX_SECTORS (MaxSectors),
    .CORDIC_STEPS(CordicSteps)
  ) DUT (.*);

  // Clock with period 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Predictor state and its copy of the registers.
  longint      cur_x = 0;
  longint      cur_y = 0;
  logic        held_sel = 1'b0;
  logic [3:0]  held_idx = '0;
  int unsigned gain = 256;
  int unsigned dz_thr = 16384;
  int unsigned dz_hyst = 3277;
  int unsigned sec_count = 0;

  pointer_t    pending_pointers[$];
  int          errors = 0;
  int          items_sent = 0;
  int          clears_sent = 0;
  int          selections_seen = 0;
  int          clamps_seen = 0;
  int          cfg_writes = 0;
  int          burst_left = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] cursor_angle(input longint x, input longint y);
    int unsigned z = 0;
    longint xs, ys;
    if (x == 0 && y == 0) return 16'd0;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TBL[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TBL[i];
      end
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  // Moves the cursor, clamps it to the unit circle and picks a sector.
  function automatic pointer_t move_pointer(input logic signed [15:0] dx,
                                            input logic signed [15:0] dy);
    pointer_t r;
    longint x, y, dead;
    longint unsigned s, m, len;
    int unsigned cnt, u;
    x = cur_x + ((longint'(dx) * longint'(gain) + 128) >>> 8);
    y = cur_y - ((longint'(dy) * longint'(gain) + 128) >>> 8);
    s = longint'(x * x) + longint'(y * y);
    if (s > 64'd1073741824) begin
      m = int_sqrt(s);
      if (m * m != s) m++;
      x = (x < 0) ? -longint'((longint'(-x) * 32768) / m) : longint'((x * 32768) / m);
      y = (y < 0) ? -longint'((longint'(-y) * 32768) / m) : longint'((y * 32768) / m);
      len = 32768;
      clamps_seen++;
    end else begin
      len = int_sqrt(s);
    end
    cur_x = x;
    cur_y = y;
    r.angle = cursor_angle(x, y);
    cnt = (sec_count > 16) ? 16 : sec_count;
    dead = held_sel ? longint'(dz_thr) - longint'(dz_hyst) : longint'(dz_thr);
    if (longint'(len) >= dead && cnt > 0) begin
      u = (16384 - int'(r.angle)) & 32'hFFFF;
      held_idx = (((u * cnt) + 32768) >> 16) % cnt;
      held_sel = 1'b1;
    end else begin
      held_idx = '0;
      held_sel = 1'b0;
    end
    r.length = len[15:0];
    r.sel_valid = held_sel;
    r.sector = held_idx;
    return r;
  endfunction

  // Sends one item; valid stays high into the next item within a burst.
  task automatic send_item(input logic op, input logic [15:0] dx, input logic [15:0] dy);
    pointer_t p;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {dy, dx};
    do @(posedge clk); while (!in_tready);
    if (op == rss_pkg::OP_CLEAR) begin
      cur_x = 0;
      cur_y = 0;
      held_sel = 1'b0;
      held_idx = '0;
      p = '0;
      clears_sent++;
    end else begin
      p = move_pointer(dx, dy);
    end
    pending_pointers.push_back(p);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Waits until every expected result has come back and the block is idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pointers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      rss_pkg::REG_SENS:  gain = val & 32'hFFFF;
      rss_pkg::REG_THR:   dz_thr = val & 32'hFFFF;
      rss_pkg::REG_HYST:  dz_hyst = val & 32'hFFFF;
      rss_pkg::REG_COUNT: sec_count = val & 32'h1F;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(input int unsigned sens, input int unsigned thr,
                            input int unsigned hyst, input int unsigned cnt);
    drain();
    cfg_write(rss_pkg::REG_SENS, sens);
    cfg_write(rss_pkg::REG_THR, thr);
    cfg_write(rss_pkg::REG_HYST, hyst);
    cfg_write(rss_pkg::REG_COUNT, cnt);
  endtask

  // Field extremes, the origin, the negative x axis, clamping and clears.
  task automatic test_directed();
    send_item(rss_pkg::OP_MOVE, 16'h0000, 16'h0000);
    send_item(rss_pkg::OP_MOVE, 16'h7FFF, 16'h0000);
    send_item(rss_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
    send_item(rss_pkg::OP_MOVE, 16'hC000, 16'h0000);
    send_item(rss_pkg::OP_MOVE, 16'h8000, 16'h8000);
    send_item(rss_pkg::OP_MOVE, 16'h0000, 16'h7FFF);
    set_config(256, 16384, 3277, 8);
    send_item(rss_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    send_item(rss_pkg::OP_MOVE, 16'h0000, 16'hA000);
    send_item(rss_pkg::OP_MOVE, 16'h3000, 16'h0000);
    send_item(rss_pkg::OP_MOVE, 16'hF000, 16'h5000);
    send_item(rss_pkg::OP_MOVE, 16'h0400, 16'h0400);
    // Hysteresis above the threshold: any length selects once held.
    set_config(65535, 0, 32768, 31);
    send_item(rss_pkg::OP_MOVE, 16'h0001, 16'hFFFF);
    send_item(rss_pkg::OP_MOVE, 16'h8000, 16'h7FFF);
    send_item(rss_pkg::OP_MOVE, 16'h7FFF, 16'h8000);
    send_item(rss_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    set_config(0, 32768, 0, 1);
    send_item(rss_pkg::OP_MOVE, 16'h7FFF, 16'h7FFF);
    set_config(1, 32768, 32768, 16);
    send_item(rss_pkg::OP_MOVE, 16'h7FFF, 16'h0000);
    send_item(rss_pkg::OP_MOVE, 16'h8000, 16'h8000);
    send_item(rss_pkg::OP_MOVE, 16'h5555, 16'hAAAA);
  endtask

  function automatic logic [15:0] rand_delta();
    int r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 4095) - 2048);
    if (r < 80) return 16'($urandom_range(0, 32767) - 16384);
    return 16'($urandom);
  endfunction

  // Random walks under several register settings, with occasional clears.
  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_config(256, 16384, 3277, 8);
        1: set_config(65535, 32768, 0, 16);
        2: set_config($urandom_range(16, 512), $urandom_range(0, 32768),
                      $urandom_range(0, 32768), $urandom_range(0, 31));
        3: set_config(0, 0, 0, 2);
        default: set_config($urandom_range(32, 300), $urandom_range(4000, 30000),
                            $urandom_range(0, 8000), $urandom_range(1, 16));
      endcase
      for (int i = 0; i < 95; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(rss_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
        end else begin
          send_item(rss_pkg::OP_MOVE, rand_delta(), rand_delta());
        end
      end
    end
  endtask

  // Result receiver: the stall pattern is redrawn at random at regular intervals.
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  always @(posedge clk) begin
    pointer_t got, want;
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 0);
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ((rx_cycle / 16) % 2 == 0);
    endcase
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[32], out_tdata[36:33]};
      if (got.sel_valid) selections_seen++;
      if (pending_pointers.size() == 0) begin
        $error("result transfer with no expected result: %h", out_tdata);
        errors++;
      end else begin
        want = pending_pointers.pop_front();
        if (got.angle !== want.angle) begin
          $error("pointer_angle: expected %h, got %h", want.angle, got.angle);
          errors++;
        end
        if (got.length !== want.length) begin
          $error("pointer_length: expected %h, got %h", want.length, got.length);
          errors++;
        end
        if (got.sel_valid !== want.sel_valid) begin
          $error("selection_valid: expected %b, got %b", want.sel_valid, got.sel_valid);
          errors++;
        end
        if (got.sector !== want.sector) begin
          $error("selected_sector: expected %0d, got %0d", want.sector, got.sector);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_random();
    drain();
    repeat (150) @(posedge clk);
    if (pending_pointers.size() != 0) begin
      $error("%0d expected results never arrived", pending_pointers.size());
      errors++;
    end
    $display("Sent %0d items (%0d clears) over %0d register writes.",
             items_sent, clears_sent, cfg_writes);
    $display("Saw %0d selections and %0d unit circle clamps.", selections_seen, clamps_seen);
    if (errors == 0) begin
      $display("radial_sector_selector: match");
    end else begin
      $display("radial_sector_selector: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8000000;
    $display("radial_sector_selector: mismatch");
    $finish;
  end

endmodule
